// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mp22_pkg.sv =====
`timescale 1ns / 1ps
package mp22_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_IN_WIDTH      = 2'd0;
    localparam logic [IDX_W-1:0] REG_IN_HEIGHT     = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

    // True when float a is ordered-less than float b (NaN compares false)
    function automatic logic f_less(input word_t a, input word_t b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic res;
        a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_zero && b_zero))
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (a[31] == 1'b0)
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

    // first operand unless ordered-less than the second
    function automatic word_t f_max(input word_t a, input word_t b);
        return f_less(a, b) ? b : a;
    endfunction

endpackage

// ===== src/mp22_stream_if.sv =====
`timescale 1ns / 1ps
interface mp22_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    logic         last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

// ===== src/max_pool_2x2_stride2.sv =====
// A pixel that closes a window shows its result on out_ch after it has passed
// the stage 1 registers, then the result register.
// Throughput: one pixel per cycle while out_ch takes results; the line-store
// read port and the two-stage pipeline (read/compare, result register) set it.
// Reset: rst_n asynchronous low clears counters, valids and registers to
// width 2, height 2, one channel; the line store is not cleared.
`timescale 1ns / 1ps
module max_pool_2x2_stride2
    import mp22_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    mp22_stream_if.sink        in_ch,
    mp22_stream_if.source      out_ch
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int SW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] chan_reg;

    logic [CW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [15:0]   nc_eff;

    logic [CW-1:0] col_reg;
    logic [12:0]   row_reg;
    logic [15:0]   ch_reg;
    word_t         left_reg;

    word_t line_mem [DEPTH];

    // stage 1
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    word_t         s1_pm_reg;
    word_t         s1_top_reg;

    // stage 2
    logic          out_valid_reg;
    word_t         out_data_reg;
    logic          out_last_reg;

    logic accept;
    logic stall;
    word_t pm;
    logic [SW-1:0] slot;
    logic odd_col;
    logic odd_row;
    logic last_hit;
    logic cfg_hit;

    // effective sizes with saturation
    always_comb
    begin
        if (width_reg < 13'd2)
            w_eff = CW'(2);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);
        if (height_reg < 13'd2)
            h_eff = 13'd2;
        else if (height_reg > 13'd4096)
            h_eff = 13'd4096;
        else
            h_eff = height_reg;
        nc_eff = (chan_reg == 16'd0) ? 16'd1 : chan_reg;
    end

    assign stall   = out_valid_reg && !out_ch.ready && s1_valid_reg && s1_emit_reg;
    assign in_ch.ready = !stall;
    assign accept  = in_ch.valid && in_ch.ready;

    // only listed registers take a write
    assign cfg_hit = cfg_we && ((cfg_index == REG_IN_WIDTH) || (cfg_index == REG_IN_HEIGHT)
                             || (cfg_index == REG_CHANNEL_COUNT));

    assign odd_col = col_reg[0];
    assign odd_row = row_reg[0];
    assign slot    = SW'(col_reg >> 1);
    assign pm      = f_max(left_reg, in_ch.data);
    assign last_hit = (ch_reg == nc_eff - 16'd1)
                   && (row_reg == (h_eff & ~13'd1) - 13'd1)
                   && (col_reg == (w_eff & ~CW'(1)) - CW'(1));

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd2;
            height_reg <= 13'd2;
            chan_reg   <= 16'd1;
            col_reg    <= '0;
            row_reg    <= '0;
            ch_reg     <= '0;
            left_reg   <= '0;
        end
        else if (cfg_hit)
        begin
            unique case (cfg_index)
                REG_IN_WIDTH:      width_reg  <= cfg_data[12:0];
                REG_IN_HEIGHT:     height_reg <= cfg_data[12:0];
                REG_CHANNEL_COUNT: chan_reg   <= cfg_data;
                default:           chan_reg   <= chan_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
            ch_reg  <= '0;
        end
        else if (accept)
        begin
            if (!odd_col)
                left_reg <= in_ch.data;
            if (col_reg + CW'(1) >= w_eff)
            begin
                col_reg <= '0;
                if (row_reg + 13'd1 >= h_eff)
                begin
                    row_reg <= '0;
                    ch_reg  <= (ch_reg + 16'd1 >= nc_eff) ? 16'd0 : ch_reg + 16'd1;
                end
                else
                    row_reg <= row_reg + 13'd1;
            end
            else
                col_reg <= col_reg + CW'(1);
        end
    end

    // line store: write on even rows, registered read on every accepted pixel
    always_ff @(posedge clk)
    begin
        if (accept && odd_col && !odd_row)
            line_mem[slot] <= pm;
        if (accept)
        begin
            s1_top_reg <= line_mem[slot];
            s1_pm_reg  <= pm;
            s1_last_reg <= last_hit;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && odd_col && odd_row;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ch.ready)
            out_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || out_ch.ready) && s1_valid_reg && s1_emit_reg)
        begin
            out_data_reg <= f_max(s1_top_reg, s1_pm_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign out_ch.last  = out_last_reg;

endmodule

// ===== src/mp22_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mp22_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_data,
    input logic        in_valid,
    input logic        in_ready
);
    // a stalled result holds its value
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // input only stalls while a result is pending
    `ASSERT_IMPL(a_stall, clk, rst_n, !in_ready, out_valid && !out_ready)
    // a request is taken whenever the result side is empty
    `ASSERT_IMPL(a_src, clk, rst_n, in_valid && !out_valid, in_ready)
endmodule

bind max_pool_2x2_stride2 mp22_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready)
);
